/* hdl/vrfa_pkg.sv */
// Shared types, register codes and decode functions of the video register file access unit.
package vrfa_pkg;

   // Register file geometry.
   localparam int REGISTER_COUNT = 64;
   localparam int LOC_WIDTH      = 6;
   localparam int WORD_WIDTH     = 14;

   // Access kinds.
   typedef enum logic [0:0] {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   // Registers with a behavior of their own.
   localparam logic [LOC_WIDTH-1:0] REG_DISPLAY_ENABLE = 6'h20;
   localparam logic [LOC_WIDTH-1:0] REG_MODE_SELECT    = 6'h21;
   localparam logic [LOC_WIDTH-1:0] REG_VERSION        = 6'h22;
   localparam logic [LOC_WIDTH-1:0] REG_STACK_FIRST    = 6'h28;
   localparam logic [LOC_WIDTH-1:0] REG_STACK_LAST     = 6'h2B;
   localparam logic [LOC_WIDTH-1:0] REG_BORDER_COLOR   = 6'h2C;
   localparam logic [LOC_WIDTH-1:0] REG_HORIZ_OFFSET   = 6'h30;
   localparam logic [LOC_WIDTH-1:0] REG_VERT_OFFSET    = 6'h31;
   localparam logic [LOC_WIDTH-1:0] REG_BLOCK_EDGES    = 6'h32;

   // Version words.
   localparam logic [WORD_WIDTH-1:0] VERSION_BASE    = 14'h3FFF;
   localparam logic [WORD_WIDTH-1:0] VERSION_VARIANT = 14'h3FF7;

   // One bus access.
   typedef struct packed {
      logic        opcode;
      logic [15:0] address;
      logic [15:0] write_data;
      logic        bus_enabled;
   } req_type;

   // One access result with the current display status.
   typedef struct packed {
      logic [13:0] read_data;
      logic        display_enable_strobe;
      logic        color_stack_mode;
      logic        color_mode_changed;
      logic        color_stack_changed;
      logic [3:0]  border_color;
      logic [2:0]  horizontal_offset;
      logic [2:0]  vertical_offset;
      logic        block_left;
      logic        block_top;
   } rsp_type;

   // Value stored by a write, after the group mask.
   function automatic logic [WORD_WIDTH-1:0] write_mask(
      input logic [LOC_WIDTH-1:0] loc,
      input logic [15:0]          data
   );
      logic [WORD_WIDTH-1:0] value;
      logic [WORD_WIDTH-1:0] own_bit;
      value   = data[WORD_WIDTH-1:0];
      own_bit = '0;
      own_bit[loc[2:0]] = 1'b1;
      priority if (loc < 6'h08) begin
         write_mask = value & 14'h07FF;
      end else if (loc < 6'h10) begin
         write_mask = value & 14'h0FFF;
      end else if (loc < 6'h18) begin
         write_mask = value & 14'h3FFF;
      end else if (loc < 6'h20) begin
         // A sprite never records a collision with itself.
         write_mask = value & 14'h03FF & ~own_bit;
      end else if (loc == REG_DISPLAY_ENABLE) begin
         write_mask = value & 14'h3FFF;
      end else if (loc >= REG_STACK_FIRST && loc <= REG_BORDER_COLOR) begin
         write_mask = value & 14'h000F;
      end else if (loc == REG_HORIZ_OFFSET || loc == REG_VERT_OFFSET) begin
         write_mask = value & 14'h0007;
      end else if (loc == REG_BLOCK_EDGES) begin
         write_mask = value & 14'h0003;
      end else begin
         write_mask = '0;
      end
   endfunction

   // Value returned by an enabled read, with the always-one bits merged in.
   function automatic logic [WORD_WIDTH-1:0] read_value(
      input logic [LOC_WIDTH-1:0]  loc,
      input logic [WORD_WIDTH-1:0] word,
      input logic                  variant
   );
      priority if (loc < 6'h08) begin
         read_value = 14'h3800 | word;
      end else if (loc < 6'h10) begin
         read_value = 14'h3000 | word;
      end else if (loc < 6'h18) begin
         read_value = word;
      end else if (loc < 6'h20) begin
         read_value = 14'h3C00 | word;
      end else if (loc == REG_DISPLAY_ENABLE) begin
         read_value = '0;
      end else if (loc == REG_VERSION) begin
         read_value = variant ? VERSION_VARIANT : VERSION_BASE;
      end else if (loc >= REG_STACK_FIRST && loc <= REG_BORDER_COLOR) begin
         read_value = 14'h3FF0 | word;
      end else if (loc == REG_HORIZ_OFFSET || loc == REG_VERT_OFFSET) begin
         read_value = 14'h3FF8 | word;
      end else if (loc == REG_BLOCK_EDGES) begin
         read_value = 14'h3FFC | word;
      end else begin
         read_value = word;
      end
   endfunction

endpackage

/* hdl/video_register_file_access_unit.sv */
// Top level of the video register file access unit.
//
// A bus access word is taken on req_word at a rising edge where start is high
// and busy is low. busy stays low: a new access may be issued in every cycle.
// Each access gives exactly one result word on rsp_word, marked by rsp_valid
// for a single cycle; the receiver cannot stall, so the word must be taken then.
// Throughput is one access per cycle. The read stage reads the register file
// memory (one synchronous read port); the update stage merges the word, updates
// the mode flag and writes back. A read that follows a write to the same register
// in the next cycle takes the written value through a forwarding path.
// The chip revision is set through csr_write_enable and csr_write_data; the user
// must write it only while no access is in flight; the block does not enforce it.
// Reset clears the per-entry valid bits, so every stored word is taken as zero
// afterwards; it also clears the mode flag, the status copies and the revision
// bit. No clearing pass is needed and the block is ready at once.
module video_register_file_access_unit #(
   parameter int REGISTER_COUNT = vrfa_pkg::REGISTER_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vrfa_pkg::req_type req_word,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output logic              rsp_valid,
   output vrfa_pkg::rsp_type rsp_word
);

   localparam int IndexWidth = $clog2(REGISTER_COUNT);

   // Register file storage, no reset; valid bits stand for the zero reset.
   logic [vrfa_pkg::WORD_WIDTH-1:0] mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0]       valid_ff;
   logic [REGISTER_COUNT-1:0]       valid_in;

   // Read stage.
   logic                            accept;
   logic [IndexWidth-1:0]           rd_index;
   logic [vrfa_pkg::WORD_WIDTH-1:0] mem_rd_ff;
   logic                            entry_valid_ff;
   logic                            entry_valid_in;
   logic                            fwd_ff;
   logic                            fwd_in;
   logic [vrfa_pkg::WORD_WIDTH-1:0] fwd_data_ff;

   // Update stage.
   logic                            s1_valid_ff;
   vrfa_pkg::req_type               s1_req_ff;
   logic [vrfa_pkg::LOC_WIDTH-1:0]  s1_loc;
   logic [IndexWidth-1:0]           s1_index;
   logic                            s1_write;
   logic [vrfa_pkg::WORD_WIDTH-1:0] s1_word;
   logic [vrfa_pkg::WORD_WIDTH-1:0] s1_wval;

   // Control and status state.
   logic        variant_ff;
   logic        mode_ff;
   logic        mode_in;
   logic        mode_changed;
   logic [3:0]  border_ff;
   logic [3:0]  border_in;
   logic [2:0]  hoff_ff;
   logic [2:0]  hoff_in;
   logic [2:0]  voff_ff;
   logic [2:0]  voff_in;
   logic [1:0]  edges_ff;
   logic [1:0]  edges_in;
   logic [13:0] read_data;

   // Result register.
   logic              rsp_valid_ff;
   vrfa_pkg::rsp_type rsp_ff;
   vrfa_pkg::rsp_type rsp_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign rd_index = req_word.address[IndexWidth-1:0];

   assign s1_loc   = s1_req_ff.address[vrfa_pkg::LOC_WIDTH-1:0];
   assign s1_index = s1_req_ff.address[IndexWidth-1:0];
   assign s1_write = s1_valid_ff && (s1_req_ff.opcode == vrfa_pkg::OP_WRITE)
                     && s1_req_ff.bus_enabled;
   assign s1_wval  = vrfa_pkg::write_mask(s1_loc, s1_req_ff.write_data);

   // A read issued while the previous access writes the same entry forwards it.
   assign fwd_in         = s1_write && (s1_index == rd_index);
   assign entry_valid_in = valid_ff[rd_index];

   // Stored word as seen by the access in the update stage.
   always_comb begin
      if (fwd_ff) begin
         s1_word = fwd_data_ff;
      end else if (entry_valid_ff) begin
         s1_word = mem_rd_ff;
      end else begin
         s1_word = '0;
      end
   end

   // Memory read and write ports.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= mem[rd_index];
      end
      if (s1_write) begin
         mem[s1_index] <= s1_wval;
      end
   end

   // Valid bits are set by the first write of each entry.
   always_comb begin
      valid_in = valid_ff;
      if (s1_write) begin
         valid_in[s1_index] = 1'b1;
      end
   end

   // Mode flag, status copies and read data of the access in the update stage.
   always_comb begin
      mode_in      = mode_ff;
      mode_changed = 1'b0;
      border_in    = border_ff;
      hoff_in      = hoff_ff;
      voff_in      = voff_ff;
      edges_in     = edges_ff;
      read_data    = '0;
      if (s1_write) begin
         if (s1_loc == vrfa_pkg::REG_MODE_SELECT && mode_ff) begin
            mode_in      = 1'b0;
            mode_changed = 1'b1;
         end
         if (s1_loc == vrfa_pkg::REG_BORDER_COLOR) begin
            border_in = s1_wval[3:0];
         end
         if (s1_loc == vrfa_pkg::REG_HORIZ_OFFSET) begin
            hoff_in = s1_wval[2:0];
         end
         if (s1_loc == vrfa_pkg::REG_VERT_OFFSET) begin
            voff_in = s1_wval[2:0];
         end
         if (s1_loc == vrfa_pkg::REG_BLOCK_EDGES) begin
            edges_in = s1_wval[1:0];
         end
      end else if (s1_valid_ff && (s1_req_ff.opcode == vrfa_pkg::OP_READ)) begin
         if (!s1_req_ff.bus_enabled) begin
            // Disabled bus: the bus floats back the low address bits.
            read_data = s1_req_ff.address[13:0];
         end else begin
            if (s1_loc == vrfa_pkg::REG_MODE_SELECT && !mode_ff) begin
               mode_in      = 1'b1;
               mode_changed = 1'b1;
            end
            read_data = vrfa_pkg::read_value(s1_loc, s1_word, variant_ff);
         end
      end
   end

   // Result word.
   always_comb begin
      rsp_in.read_data             = read_data;
      rsp_in.display_enable_strobe = s1_write
                                     && (s1_loc == vrfa_pkg::REG_DISPLAY_ENABLE);
      rsp_in.color_stack_mode      = mode_in;
      rsp_in.color_mode_changed    = mode_changed;
      rsp_in.color_stack_changed   = s1_write
                                     && (s1_loc >= vrfa_pkg::REG_STACK_FIRST)
                                     && (s1_loc <= vrfa_pkg::REG_STACK_LAST);
      rsp_in.border_color          = border_in;
      rsp_in.horizontal_offset     = hoff_in;
      rsp_in.vertical_offset       = voff_in;
      rsp_in.block_left            = edges_in[0];
      rsp_in.block_top             = edges_in[1];
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff      <= req_word;
         fwd_ff         <= fwd_in;
         fwd_data_ff    <= s1_wval;
         entry_valid_ff <= entry_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         variant_ff   <= 1'b0;
         mode_ff      <= 1'b0;
         border_ff    <= '0;
         hoff_ff      <= '0;
         voff_ff      <= '0;
         edges_ff     <= '0;
      end else begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
         valid_ff     <= valid_in;
         mode_ff      <= mode_in;
         border_ff    <= border_in;
         hoff_ff      <= hoff_in;
         voff_ff      <= voff_in;
         edges_ff     <= edges_in;
         if (csr_write_enable) begin
            variant_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
